/* src/sli_pkg.sv */
// Package for the segment_line_intersection block: shared widths and defaults.
// No dependencies.
`default_nettype none
package sli_pkg;
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned RES_W          = 32;
  localparam int unsigned DIV_STEPS      = 32;

  // Per-item control that travels down the divider stages.
  typedef struct packed {
    logic vld;
    logic par;
    logic ovfx;
    logic ovfy;
    logic negx;
    logic negy;
  } sli_ctl_t;
endpackage
`default_nettype wire

/* src/segment_line_intersection.sv */
// Top level of segment_line_intersection: exact integer crossing point of two lines.
// Depends on sli_pkg for widths and the per-stage control struct.
//
// Usage: the input channel (valid_i / stall_o) carries one item of eight signed
// coordinates, the end points of lines A and B. The output channel (valid_o /
// stall_i) returns one item per input item: cross_x_o, cross_y_o and
// lines_parallel_o. An item is taken when valid is high and stall is low.
// From acceptance to the result appearing on valid_o an item passes through
// five stages of difference, product and magnitude logic, one stage that
// checks for quotient overflow, 32 restoring divide stages (one quotient bit
// each, x and y side by side) and the output register. Throughput is one item
// per cycle while the receiver does not stall.
// When the receiver stalls while a result is shown, the whole pipeline holds
// and stall_o is raised in the same cycle, so nothing is lost or repeated.
// Reset clears every valid bit; data registers are not reset.
// When the denominator is zero both coordinates are -1 and lines_parallel_o is
// set. Quotients beyond the 32-bit signed range saturate.
`default_nettype none
module segment_line_intersection #(
  parameter int unsigned COORD_BITS = sli_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   stall_o,
  input  logic signed [COORD_BITS-1:0]           seg_a_start_x_i,
  input  logic signed [COORD_BITS-1:0]           seg_a_start_y_i,
  input  logic signed [COORD_BITS-1:0]           seg_a_end_x_i,
  input  logic signed [COORD_BITS-1:0]           seg_a_end_y_i,
  input  logic signed [COORD_BITS-1:0]           seg_b_start_x_i,
  input  logic signed [COORD_BITS-1:0]           seg_b_start_y_i,
  input  logic signed [COORD_BITS-1:0]           seg_b_end_x_i,
  input  logic signed [COORD_BITS-1:0]           seg_b_end_y_i,
  output logic                                   valid_o,
  input  logic                                   stall_i,
  output logic signed [sli_pkg::RES_W-1:0]       cross_x_o,
  output logic signed [sli_pkg::RES_W-1:0]       cross_y_o,
  output logic                                   lines_parallel_o
);
  import sli_pkg::*;

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned DFW = C + 1;          // coordinate differences
  localparam int unsigned PW  = 2 * C;          // coordinate products
  localparam int unsigned CW  = 2 * C + 1;      // line constants cA, cB
  localparam int unsigned MW  = 2 * C + 2;      // difference products
  localparam int unsigned DW  = 2 * C + 3;      // denominator
  localparam int unsigned TW  = 3 * C + 2;      // numerator terms
  localparam int unsigned NW  = 3 * C + 3;      // numerator
  localparam int unsigned RW  = DW + 1;         // partial remainder
  localparam int unsigned EW  = NW + RES_W;     // numerator with quotient room

  // The whole pipeline moves unless a shown result is stalled.
  logic adv;
  assign adv     = !(valid_o && stall_i);
  assign stall_o = !adv;

  // Stage 1: differences and the coordinate products of cA and cB.
  logic                  v1_q;
  logic signed [DFW-1:0] dax_q, day_q, dbx_q, dby_q;
  logic signed [PW-1:0]  p1_q, p2_q, p3_q, p4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dax_q <= DFW'(seg_a_end_x_i) - DFW'(seg_a_start_x_i);
      day_q <= DFW'(seg_a_end_y_i) - DFW'(seg_a_start_y_i);
      dbx_q <= DFW'(seg_b_end_x_i) - DFW'(seg_b_start_x_i);
      dby_q <= DFW'(seg_b_end_y_i) - DFW'(seg_b_start_y_i);
      p1_q  <= PW'(seg_a_end_y_i) * PW'(seg_a_start_x_i);
      p2_q  <= PW'(seg_a_start_y_i) * PW'(seg_a_end_x_i);
      p3_q  <= PW'(seg_b_start_y_i) * PW'(seg_b_end_x_i);
      p4_q  <= PW'(seg_b_end_y_i) * PW'(seg_b_start_x_i);
    end
  end

  // Stage 2: line constants and the two denominator products.
  logic                  v2_q;
  logic signed [DFW-1:0] dax2_q, day2_q, dbx2_q, dby2_q;
  logic signed [CW-1:0]  ca_q, cb_q;
  logic signed [MW-1:0]  m1_q, m2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dax2_q <= dax_q;
      day2_q <= day_q;
      dbx2_q <= dbx_q;
      dby2_q <= dby_q;
      ca_q   <= CW'(p1_q) - CW'(p2_q);
      cb_q   <= CW'(p3_q) - CW'(p4_q);
      m1_q   <= MW'(dbx_q) * MW'(day_q);
      m2_q   <= MW'(dax_q) * MW'(dby_q);
    end
  end

  // Stage 3: denominator and the four numerator terms.
  logic                 v3_q;
  logic signed [DW-1:0] den3_q;
  logic signed [TW-1:0] tx1_q, tx2_q, ty1_q, ty2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      den3_q <= DW'(m1_q) - DW'(m2_q);
      tx1_q  <= TW'(dax2_q) * TW'(cb_q);
      tx2_q  <= TW'(dbx2_q) * TW'(ca_q);
      ty1_q  <= TW'(day2_q) * TW'(cb_q);
      ty2_q  <= TW'(dby2_q) * TW'(ca_q);
    end
  end

  // Stage 4: numerator sums.
  logic                 v4_q;
  logic signed [DW-1:0] den4_q;
  logic signed [NW-1:0] numx_q, numy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      den4_q <= den3_q;
      numx_q <= NW'(tx1_q) + NW'(tx2_q);
      numy_q <= NW'(ty1_q) + NW'(ty2_q);
    end
  end

  // Stage 5: magnitudes, quotient signs and the parallel flag.
  logic          v5_q, par5_q, negx5_q, negy5_q;
  logic [DW-1:0] dmag_q;
  logic [NW-1:0] magx_q, magy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (adv) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dmag_q  <= den4_q[DW-1] ? (~den4_q + 1'b1) : den4_q;
      magx_q  <= numx_q[NW-1] ? (~numx_q + 1'b1) : numx_q;
      magy_q  <= numy_q[NW-1] ? (~numy_q + 1'b1) : numy_q;
      par5_q  <= (den4_q == '0);
      negx5_q <= numx_q[NW-1] != den4_q[DW-1];
      negy5_q <= numy_q[NW-1] != den4_q[DW-1];
    end
  end

  // Stage 6 feeds the divider: overflow check and the initial remainder.
  // Without overflow the top part of the numerator is below the divisor.
  logic [EW-1:0] extx, exty, dshift;
  logic [EW-1:0] shx, shy;
  assign extx   = EW'(magx_q);
  assign exty   = EW'(magy_q);
  assign dshift = EW'({dmag_q, {RES_W{1'b0}}});
  assign shx    = extx >> RES_W;
  assign shy    = exty >> RES_W;

  sli_ctl_t             ctl_q  [DIV_STEPS+1];
  logic [DW-1:0]        d_q    [DIV_STEPS+1];
  logic [RW-1:0]        remx_q [DIV_STEPS+1];
  logic [RW-1:0]        remy_q [DIV_STEPS+1];
  logic [RES_W-1:0]     lowx_q [DIV_STEPS+1];
  logic [RES_W-1:0]     lowy_q [DIV_STEPS+1];
  logic [RES_W-1:0]     qx_q   [DIV_STEPS+1];
  logic [RES_W-1:0]     qy_q   [DIV_STEPS+1];

  // The control word is kept whole in one block so that it has one driver.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q[0] <= '0;
    end else if (adv) begin
      ctl_q[0].vld  <= v5_q;
      ctl_q[0].par  <= par5_q;
      ctl_q[0].ovfx <= extx >= dshift;
      ctl_q[0].ovfy <= exty >= dshift;
      ctl_q[0].negx <= negx5_q;
      ctl_q[0].negy <= negy5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_q[0]        <= dmag_q;
      remx_q[0]     <= shx[RW-1:0];
      remy_q[0]     <= shy[RW-1:0];
      lowx_q[0]     <= extx[RES_W-1:0];
      lowy_q[0]     <= exty[RES_W-1:0];
      qx_q[0]       <= '0;
      qy_q[0]       <= '0;
    end
  end

  // Restoring divide stages, one quotient bit per stage for each axis.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [RW-1:0] tx, ty, dext;
    logic          gex, gey;
    assign dext = {1'b0, d_q[k]};
    assign tx   = {remx_q[k][RW-2:0], lowx_q[k][RES_W-1]};
    assign ty   = {remy_q[k][RW-2:0], lowy_q[k][RES_W-1]};
    assign gex  = tx >= dext;
    assign gey  = ty >= dext;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k+1] <= '0;
      end else if (adv) begin
        ctl_q[k+1] <= ctl_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        d_q[k+1]        <= d_q[k];
        remx_q[k+1]     <= gex ? (tx - dext) : tx;
        remy_q[k+1]     <= gey ? (ty - dext) : ty;
        lowx_q[k+1]     <= {lowx_q[k][RES_W-2:0], 1'b0};
        lowy_q[k+1]     <= {lowy_q[k][RES_W-2:0], 1'b0};
        qx_q[k+1]       <= {qx_q[k][RES_W-2:0], gex};
        qy_q[k+1]       <= {qy_q[k][RES_W-2:0], gey};
      end
    end
  end

  // Signs the unsigned quotient and clamps it to the 32-bit signed range.
  function automatic logic [RES_W-1:0] sat_q(input logic [RES_W-1:0] q,
                                             input logic ovf, input logic neg);
    logic [RES_W-1:0] smin, smax;
    smin = {1'b1, {(RES_W-1){1'b0}}};
    smax = {1'b0, {(RES_W-1){1'b1}}};
    if (ovf) begin
      sat_q = neg ? smin : smax;
    end else if (neg) begin
      sat_q = q[RES_W-1] ? smin : (~q + 1'b1);
    end else begin
      sat_q = q[RES_W-1] ? smax : q;
    end
  endfunction

  sli_ctl_t         ctl_end;
  logic [RES_W-1:0] resx_d, resy_d;
  assign ctl_end = ctl_q[DIV_STEPS];
  assign resx_d  = ctl_end.par ? '1 : sat_q(qx_q[DIV_STEPS], ctl_end.ovfx, ctl_end.negx);
  assign resy_d  = ctl_end.par ? '1 : sat_q(qy_q[DIV_STEPS], ctl_end.ovfy, ctl_end.negy);

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (adv) begin
      valid_o <= ctl_end.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cross_x_o        <= resx_d;
      cross_y_o        <= resy_d;
      lines_parallel_o <= ctl_end.par;
    end
  end

  // A parallel result always reports -1 on both axes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && lines_parallel_o |-> cross_x_o == '1 && cross_y_o == '1)
    else $error("parallel result without -1 coordinates");

  // The input side is held back only by a waiting result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("input stalled without a stalled result");

  // A held pipeline does not advance the divider chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |=> $stable(ctl_q[DIV_STEPS].vld))
    else $error("divider advanced during stall");
endmodule
`default_nettype wire

/* sim/segment_line_intersection_test.sv */
// Testbench for segment_line_intersection: drives pairs of lines and checks the crossing point.
// Depends on sli_pkg and the segment_line_intersection RTL.
`default_nettype none
module segment_line_intersection_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW = sli_pkg::COORD_BITS_DEF;
  localparam int unsigned RW = sli_pkg::RES_W;
  localparam int N_RANDOM = 1650;
  localparam logic signed [RW-1:0] PARALLEL_MARK = -1;
  localparam logic signed [RW-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [RW-1:0] SAT_MIN = 32'sh8000_0000;

  // One input item: the eight end-point coordinates of lines A and B.
  typedef struct packed {
    logic signed [CW-1:0] asx, asy, aex, aey, bsx, bsy, bex, bey;
  } line_pair_t;

  // One result item as the block presents it.
  typedef struct packed {
    logic signed [RW-1:0] x;
    logic signed [RW-1:0] y;
    logic                 par;
  } crossing_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic stall_o, valid_o, lines_parallel_o;
  logic signed [CW-1:0] sax = '0, say = '0, eax = '0, eay = '0;
  logic signed [CW-1:0] sbx = '0, sby = '0, ebx = '0, eby = '0;
  logic signed [RW-1:0] cross_x_o, cross_y_o;

  line_pair_t pending_pairs[$];
  crossing_t  expected_crossings[$];
  int mismatches = 0;
  bit stimulus_done = 1'b0;
  // While quiet is set neither side inserts idle cycles.
  bit quiet = 1'b0;

  always #5 clk_i = ~clk_i;

  segment_line_intersection u_top (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .seg_a_start_x_i(sax), .seg_a_start_y_i(say),
    .seg_a_end_x_i(eax), .seg_a_end_y_i(eay),
    .seg_b_start_x_i(sbx), .seg_b_start_y_i(sby),
    .seg_b_end_x_i(ebx), .seg_b_end_y_i(eby),
    .valid_o, .stall_i, .cross_x_o, .cross_y_o, .lines_parallel_o
  );

  // Truncating quotient of two exact integers, clamped to 32 signed bits.
  // SystemVerilog division of signed vectors already truncates toward zero.
  function automatic logic signed [RW-1:0] clamp_quotient(logic signed [127:0] num,
                                                           logic signed [127:0] den);
    logic signed [127:0] q;
    q = num / den;
    if (q > 128'sh7FFF_FFFF) return SAT_MAX;
    if (q < -128'sh8000_0000) return SAT_MIN;
    return q[RW-1:0];
  endfunction

  // Crossing point of the two infinite lines, worked out with wide exact integers.
  function automatic crossing_t line_crossing(line_pair_t p);
    logic signed [127:0] dax, day, dbx, dby, den, ca, cb;
    crossing_t r;
    dax = 128'(p.aex) - 128'(p.asx);
    day = 128'(p.aey) - 128'(p.asy);
    dbx = 128'(p.bex) - 128'(p.bsx);
    dby = 128'(p.bey) - 128'(p.bsy);
    den = dbx * day - dax * dby;
    ca  = 128'(p.aey) * 128'(p.asx) - 128'(p.asy) * 128'(p.aex);
    cb  = 128'(p.bsy) * 128'(p.bex) - 128'(p.bey) * 128'(p.bsx);
    if (den == 0) begin
      r.x = PARALLEL_MARK;
      r.y = PARALLEL_MARK;
      r.par = 1'b1;
    end else begin
      r.x = clamp_quotient(dax * cb + dbx * ca, den);
      r.y = clamp_quotient(day * cb + dby * ca, den);
      r.par = 1'b0;
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] any_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1: return CW'($signed($urandom_range(0, 40)) - 20);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic line_pair_t pair_of(int a, int b, int c, int d,
                                         int e, int f, int g, int h);
    line_pair_t p;
    p.asx = CW'(a); p.asy = CW'(b); p.aex = CW'(c); p.aey = CW'(d);
    p.bsx = CW'(e); p.bsy = CW'(f); p.bex = CW'(g); p.bey = CW'(h);
    return p;
  endfunction

  // Directed items first, then random pairs of several kinds.
  initial begin
    line_pair_t p;
    int k;
    // Plain crossing of two diagonals.
    pending_pairs.push_back(pair_of(0, 0, 10, 10, 0, 10, 10, 0));
    // Horizontal against vertical line.
    pending_pairs.push_back(pair_of(-5, 3, 5, 3, 2, -7, 2, 9));
    // Parallel lines, then a degenerate line with both points equal.
    pending_pairs.push_back(pair_of(0, 0, 4, 2, 1, 1, 5, 3));
    pending_pairs.push_back(pair_of(7, 7, 7, 7, 0, 1, 3, 9));
    // All coordinates zero and all at the extremes.
    pending_pairs.push_back(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(pair_of(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768));
    // Full-range lines: two parallel pairs, then two crossing diagonals.
    pending_pairs.push_back(pair_of(-32768, -32768, 32767, 32766, -32768, -32767, 32767, 32767));
    pending_pairs.push_back(pair_of(-32768, 32767, 32767, -32767, -32768, 32766, 32767, -32768));
    pending_pairs.push_back(pair_of(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
    // Crossings near the origin, some at negative or fractional coordinates (truncation toward zero).
    pending_pairs.push_back(pair_of(0, 0, 3, 1, -1, 0, -1, 5));
    pending_pairs.push_back(pair_of(0, 0, -3, -1, 1, 0, 1, -5));
    pending_pairs.push_back(pair_of(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
    pending_pairs.push_back(pair_of(1, -32768, -1, 32767, 32767, 1, -32768, -1));
    for (k = 0; k < N_RANDOM; k++) begin
      case ($urandom_range(0, 9))
        0: begin
          // Parallel by construction unless a coordinate wraps: B is A shifted.
          p.asx = any_coord(); p.asy = any_coord();
          p.aex = p.asx + CW'($urandom_range(0, 30)); p.aey = p.asy + CW'($urandom_range(0, 30));
          p.bsx = any_coord(); p.bsy = any_coord();
          p.bex = p.bsx + (p.aex - p.asx); p.bey = p.bsy + (p.aey - p.asy);
        end
        1: begin
          // Nearly parallel: B direction differs from A by at most one unit on each axis.
          p.asx = any_coord(); p.asy = any_coord();
          p.aex = CW'($urandom); p.aey = CW'($urandom);
          p.bsx = any_coord(); p.bsy = any_coord();
          p.bex = p.bsx + (p.aex - p.asx) + CW'($urandom_range(0, 1));
          p.bey = p.bsy + (p.aey - p.asy) + CW'($urandom_range(0, 1));
        end
        2: p = pair_of($urandom_range(0, 60) - 30, $urandom_range(0, 60) - 30,
                       $urandom_range(0, 60) - 30, $urandom_range(0, 60) - 30,
                       $urandom_range(0, 60) - 30, $urandom_range(0, 60) - 30,
                       $urandom_range(0, 60) - 30, $urandom_range(0, 60) - 30);
        default: begin
          p.asx = any_coord(); p.asy = any_coord(); p.aex = any_coord(); p.aey = any_coord();
          p.bsx = any_coord(); p.bsy = any_coord(); p.bex = any_coord(); p.bey = any_coord();
        end
      endcase
      pending_pairs.push_back(p);
    end
  end

  // Reset once; quiet stretch covers the middle of the random part.
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (600) @(posedge clk_i);
    quiet <= 1'b1;
    repeat (400) @(posedge clk_i);
    quiet <= 1'b0;
  end

  // Driver: an item is held until accepted, then the next one or an idle cycle follows.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!valid_i || !stall_o) begin
        if (pending_pairs.size() != 0 && (quiet || $urandom_range(0, 99) >= 16)) begin
          line_pair_t p;
          p = pending_pairs.pop_front();
          expected_crossings.push_back(line_crossing(p));
          {sax, say, eax, eay, sbx, sby, ebx, eby} <= p;
          valid_i <= 1'b1;
        end else begin
          valid_i <= 1'b0;
          if (pending_pairs.size() == 0) stimulus_done <= 1'b1;
        end
      end
    end
  end

  // Monitor: random stall toward the block, and the check of each accepted result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o && !stall_i) begin
        crossing_t want;
        if (expected_crossings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result x=%0d y=%0d", cross_x_o, cross_y_o);
        end else begin
          want = expected_crossings.pop_front();
          if (cross_x_o !== want.x || cross_y_o !== want.y || lines_parallel_o !== want.par) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected x=%0d y=%0d par=%0b, got x=%0d y=%0d par=%0b",
                       want.x, want.y, want.par, cross_x_o, cross_y_o, lines_parallel_o);
          end
        end
      end
      stall_i <= !quiet && ($urandom_range(0, 99) < 16);
    end
  end

  // Normal end: all items sent and all results back, then a final check for stray results.
  initial begin
    wait (stimulus_done && expected_crossings.size() == 0);
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && expected_crossings.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
